@@ rtl/core/lrt_pkg.sv @@
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types and sizes for the recency tracker: table size, key width,
// command codes and the command and response payloads.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 32;

  // Width of the key field on the ports, fixed by the command format.
  localparam int PORT_KEY_BITS = 32;

  // Keys are masked to KEY_BITS and arrive on a fixed port, so a slot never
  // needs more bits than the narrower of the two.
  localparam int SLOT_KEY_BITS = (KEY_BITS < PORT_KEY_BITS) ? KEY_BITS : PORT_KEY_BITS;
  localparam int RANK_BITS     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS      = $clog2(ENTRIES + 1);
  localparam int OCC_BITS      = 5;

  typedef enum logic [1:0] {
    ACT_TOUCH  = 2'd0,
    ACT_EVICT  = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef struct packed {
    action_t                  action;
    logic [PORT_KEY_BITS-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic                     was_present;
    logic                     evicted_valid;
    logic [PORT_KEY_BITS-1:0] evicted_key;
    logic                     rejected;
    logic [OCC_BITS-1:0]      occupancy;
  } rsp_t;

endpackage

@@ rtl/core/lru_recency_tracker.sv @@
// ----------------------------------------------------------------------------
// lru_recency_tracker
// Recency-ordered key set held in a table of slots with a valid bit and a
// rank each; rank 0 is the most recent entry.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload | handshake
//   --------+-----------+---------+---------------------------
//   cmd     | in        | cmd_t   | cmd_valid / cmd_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// One command is taken in every cycle while the command channel is not
// stalled. A command is held in the command register, is resolved there
// against all slots at once by the parallel tag compare and rank update,
// and its response is then registered in the response register.
// Reset clears the valid bits, ranks, count and both valid flags at once.
// A stalled response holds the response register, and the command register
// then stalls the command channel until the response has been transferred.
// ----------------------------------------------------------------------------
module lru_recency_tracker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  lrt_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lrt_pkg::rsp_t rsp
);
  import lrt_pkg::*;

  logic                     cmd_q_valid;
  cmd_t                     cmd_q;
  logic                     advance;

  logic [SLOT_KEY_BITS-1:0] slot_key   [ENTRIES];
  logic [ENTRIES-1:0]       slot_valid;
  logic [RANK_BITS-1:0]     slot_rank  [ENTRIES];
  logic [CNT_BITS-1:0]      held_count;

  logic [SLOT_KEY_BITS-1:0] slot_key_next   [ENTRIES];
  logic [ENTRIES-1:0]       slot_valid_next;
  logic [RANK_BITS-1:0]     slot_rank_next  [ENTRIES];
  logic [CNT_BITS-1:0]      held_count_next;
  rsp_t                     rsp_next;

  logic [SLOT_KEY_BITS-1:0] k;
  logic [ENTRIES-1:0]       hit;
  logic [ENTRIES-1:0]       lru;
  logic [ENTRIES-1:0]       free_oh;
  logic [ENTRIES-1:0]       sel;
  logic [RANK_BITS-1:0]     last_rank;
  logic [RANK_BITS-1:0]     sel_rank;
  logic [SLOT_KEY_BITS-1:0] sel_key;
  logic                     hit_any;
  logic                     empty;

  assign advance   = cmd_q_valid && !(rsp_valid && rsp_stall);
  assign cmd_stall = cmd_q_valid && rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      cmd_q_valid <= 1'b1;
    end else if (advance) begin
      cmd_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_q <= cmd;
    end
  end

  always_comb begin
    k         = cmd_q.key[SLOT_KEY_BITS-1:0];
    last_rank = RANK_BITS'(held_count - 1'b1);
    empty     = (held_count == '0);
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = slot_valid[i] && (slot_key[i] == k);
      lru[i] = slot_valid[i] && (slot_rank[i] == last_rank);
    end
    hit_any = |hit;
    // Lowest clear bit of the valid vector: the free slot with lowest index.
    free_oh = ~slot_valid & (slot_valid + 1'b1);

    sel = '0;
    unique case (cmd_q.action)
      ACT_TOUCH:  sel = hit;
      ACT_EVICT:  sel = lru;
      ACT_REMOVE: sel = hit;
      default:    sel = '0;
    endcase

    sel_rank = '0;
    sel_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        sel_rank = sel_rank | slot_rank[i];
        sel_key  = sel_key | slot_key[i];
      end
    end

    slot_key_next   = slot_key;
    slot_valid_next = slot_valid;
    slot_rank_next  = slot_rank;
    held_count_next = held_count;
    rsp_next        = '0;

    unique case (cmd_q.action)
      ACT_TOUCH: begin
        if (hit_any) begin
          // Moving a held key to the front ages only the entries ahead of it.
          rsp_next.was_present = 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit[i]) begin
              slot_rank_next[i] = '0;
            end else if (slot_valid[i] && (slot_rank[i] < sel_rank)) begin
              slot_rank_next[i] = slot_rank[i] + 1'b1;
            end
          end
        end else if (free_oh == '0) begin
          rsp_next.rejected = 1'b1;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (free_oh[i]) begin
              slot_key_next[i]   = k;
              slot_valid_next[i] = 1'b1;
              slot_rank_next[i]  = '0;
            end else if (slot_valid[i]) begin
              slot_rank_next[i] = slot_rank[i] + 1'b1;
            end
          end
          held_count_next = held_count + 1'b1;
        end
      end
      ACT_EVICT, ACT_REMOVE: begin
        if ((cmd_q.action == ACT_EVICT) ? !empty : hit_any) begin
          if (cmd_q.action == ACT_EVICT) begin
            rsp_next.evicted_valid = 1'b1;
            rsp_next.evicted_key   = PORT_KEY_BITS'(sel_key);
          end else begin
            rsp_next.was_present = 1'b1;
          end
          for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i]) begin
              slot_valid_next[i] = 1'b0;
              slot_rank_next[i]  = '0;
            end else if (slot_valid[i] && (slot_rank[i] > sel_rank)) begin
              slot_rank_next[i] = slot_rank[i] - 1'b1;
            end
          end
          held_count_next = held_count - 1'b1;
        end
      end
      default: begin
      end
    endcase

    rsp_next.occupancy = OCC_BITS'(held_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      held_count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_rank[i] <= '0;
      end
    end else if (advance) begin
      slot_valid <= slot_valid_next;
      held_count <= held_count_next;
      slot_rank  <= slot_rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slot_key <= slot_key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/core/lrt_checker.sv @@
// ----------------------------------------------------------------------------
// lrt_checker
// Port-level checks on the recency tracker, attached by a bind statement.
// ----------------------------------------------------------------------------
module lrt_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input lrt_pkg::rsp_t rsp
);
  import lrt_pkg::*;

  // The command side is only held back by a response that cannot leave.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !cmd_stall)
    else $error("command stalled with no response waiting");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.occupancy <= OCC_BITS'(ENTRIES)))
    else $error("occupancy above table size");

  a_evict_key: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.evicted_valid) |-> (rsp.evicted_key == '0))
    else $error("evicted key set without an eviction");

  // A rejected insert only happens into a full table, and never for a held key.
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.rejected) |->
      ((rsp.occupancy == OCC_BITS'(ENTRIES)) && !rsp.was_present && !rsp.evicted_valid))
    else $error("rejection reported while the table had room");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind lru_recency_tracker lrt_checker u_lrt_checker (.*);
